// ===== design/error_latch_with_expiry_assert.svh =====
// assertion macros for the error latch with expiry
`ifndef ERROR_LATCH_WITH_EXPIRY_ASSERT_SVH
`define ERROR_LATCH_WITH_EXPIRY_ASSERT_SVH

// same-cycle implication, checked at every edge out of reset
`define ELE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("error latch assertion failed");

// next-cycle implication
`define ELE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("error latch assertion failed");

`endif

// ===== design/ele_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the error latch with expiry
package ele_pkg;

  localparam int INDEX_W = 8;
  localparam int TMO_W   = 32;
  localparam int TIME_W  = 64;
  localparam int MASK_W  = 16;
  localparam int COUNT_W = 5;
  localparam int CODE_W  = 8;

  typedef enum logic {
    CMD_REPORT = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef logic [TIME_W-1:0]  us_t;
  typedef logic [INDEX_W-1:0] index_t;
  typedef logic [TMO_W-1:0]   tmo_t;
  typedef logic [MASK_W-1:0]  mask_t;
  typedef logic [COUNT_W-1:0] log_count_t;
  typedef logic [CODE_W-1:0]  code_t;

endpackage

// ===== design/error_latch_with_expiry.sv =====
`timescale 1ns / 1ps
// error latch with expiry: per-code deadlines, active mask and a bounded event log
//
// one input channel (item_valid / item_ready) carries a beat that is either a report
// (cmd = 0) of error_index with expiry_us, or a tick (cmd = 1); both carry now_us.
// a report of a known code sets its deadline to now + timeout (saturating) and, if the
// code was idle, activates it and appends it to the log ring, dropping the oldest entry
// when full. a tick clears every active code whose deadline is at or before now.
// one output channel (result_valid / result_ready) returns exactly one result beat per
// input beat: the active mask and flags, in order.
// result_valid rises once the beat has passed the input register, then the result
// register; throughput is one beat per cycle while the receiver does not stall, set by
// the single-pass state update between the input register and result register.
// reset clears the active set and the valid bits of both registers and empties the log;
// deadlines and log contents are left as they are and are only read once written.
// when the receiver stalls, the result holds, one more beat is taken into the input
// register, and item_ready then drops until the result is taken.
`include "error_latch_with_expiry_assert.svh"

module error_latch_with_expiry
  import ele_pkg::*;
#(
  parameter int NUM_ERRORS = 16,
  parameter int LOG_DEPTH  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic       cmd,
  input  index_t     error_index,
  input  tmo_t       expiry_us,
  input  us_t        now_us,
  output logic       result_valid,
  input  logic       result_ready,
  output mask_t      active_mask,
  output logic       mask_changed,
  output logic       unknown_error,
  output logic       logged_new,
  output logic       log_dropped,
  output log_count_t log_count
);

  localparam int IDX_W  = (NUM_ERRORS > 1) ? $clog2(NUM_ERRORS) : 1;
  localparam int PTR_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int FILL_W = $clog2(LOG_DEPTH + 1);
  localparam int SUM_W  = PTR_W + 2;
  localparam int WIDE_W = (NUM_ERRORS > MASK_W) ? NUM_ERRORS : MASK_W;

  // input register
  logic   s_valid;
  logic   s_cmd;
  index_t s_index;
  tmo_t   s_tmo;
  us_t    s_now;

  // state
  logic [NUM_ERRORS-1:0] active;
  us_t                   deadline [NUM_ERRORS];
  code_t                 log_code [LOG_DEPTH];
  us_t                   log_time [LOG_DEPTH];
  logic [PTR_W-1:0]      head;
  logic [FILL_W-1:0]     fill;

  // single-pass update
  logic                  adv;
  logic                  step;
  logic                  is_report;
  logic                  known;
  logic [IDX_W-1:0]      code_idx;
  logic [TIME_W:0]       dl_sum;
  us_t                   dl;
  logic                  was_active;
  logic                  new_err;
  logic                  full;
  logic [NUM_ERRORS-1:0] expire;
  logic [NUM_ERRORS-1:0] sel_bit;
  logic [NUM_ERRORS-1:0] active_next;
  logic [SUM_W-1:0]      slot_sum;
  logic [PTR_W-1:0]      slot;
  logic [PTR_W-1:0]      head_inc;
  logic [PTR_W-1:0]      head_next;
  logic [FILL_W-1:0]     fill_next;
  logic                  changed;
  logic [WIDE_W-1:0]     wide_mask;

  assign adv        = !result_valid || result_ready;
  assign item_ready = !s_valid || adv;
  assign step       = s_valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (item_ready) begin
      s_valid <= item_valid;
    end
    if (item_valid && item_ready) begin
      s_cmd   <= cmd;
      s_index <= error_index;
      s_tmo   <= expiry_us;
      s_now   <= now_us;
    end
  end

  assign is_report  = (s_cmd == CMD_REPORT);
  assign known      = (s_index < index_t'(NUM_ERRORS));
  assign code_idx   = s_index[IDX_W-1:0];
  assign dl_sum     = (TIME_W+1)'(s_now) + (TIME_W+1)'(s_tmo);
  assign dl         = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];
  assign was_active = active[code_idx];
  assign new_err    = is_report && known && !was_active;
  assign full       = (fill >= FILL_W'(LOG_DEPTH));
  assign sel_bit    = NUM_ERRORS'(1) << code_idx;

  // parallel deadline compare, one lane per code
  always_comb begin
    for (int i = 0; i < NUM_ERRORS; i++) begin
      expire[i] = active[i] && (deadline[i] <= s_now);
    end
  end

  // next free slot; when full the new entry lands on the oldest one
  assign slot_sum = SUM_W'(head) + SUM_W'(fill);
  always_comb begin
    if (full) begin
      slot = head;
    end else if (slot_sum >= SUM_W'(LOG_DEPTH)) begin
      slot = PTR_W'(slot_sum - SUM_W'(LOG_DEPTH));
    end else begin
      slot = PTR_W'(slot_sum);
    end
  end

  assign head_inc = (head == PTR_W'(LOG_DEPTH - 1)) ? '0 : head + PTR_W'(1);

  always_comb begin
    active_next = active;
    head_next   = head;
    fill_next   = fill;
    changed     = 1'b0;
    if (!is_report) begin
      active_next = active & ~expire;
      changed     = |expire;
    end else if (new_err) begin
      active_next = active | sel_bit;
      changed     = 1'b1;
      if (full) begin
        head_next = head_inc;
      end else begin
        fill_next = fill + FILL_W'(1);
      end
    end
  end

  assign wide_mask = WIDE_W'(active_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      head   <= '0;
      fill   <= '0;
    end else if (step) begin
      active <= active_next;
      head   <= head_next;
      fill   <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && is_report && known) begin
      deadline[code_idx] <= dl;
    end
  end

  always_ff @(posedge clk) begin
    if (step && new_err) begin
      log_code[slot] <= code_t'(s_index);
      log_time[slot] <= s_now;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s_valid;
    end
    if (step) begin
      active_mask   <= wide_mask[MASK_W-1:0];
      mask_changed  <= changed;
      unknown_error <= is_report && !known;
      logged_new    <= new_err;
      log_dropped   <= new_err && full;
      log_count     <= log_count_t'(fill_next);
    end
  end

  `ELE_ASSERT_IMP(a_fill_bound, 1'b1, fill <= FILL_W'(LOG_DEPTH))
  `ELE_ASSERT_IMP(a_log_implies_change, result_valid && logged_new, mask_changed)
  `ELE_ASSERT_IMP(a_drop_when_full, result_valid && log_dropped,
                  logged_new && log_count == log_count_t'(LOG_DEPTH))
  `ELE_ASSERT_IMP(a_unknown_quiet, result_valid && unknown_error,
                  !mask_changed && !logged_new && !log_dropped)
  `ELE_ASSERT_NXT(a_tick_only_clears, step && s_cmd == CMD_TICK,
                  (active & ~$past(active)) == '0)

endmodule
